// ===== src/lrs_pkg.sv =====
// Shared types and constants for the link reconnect supervisor.
package lrs_pkg;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_RETRY_INTERVAL   = 2'd0,
    REG_MAX_ATTEMPTS     = 2'd1,
    REG_AUTO_RESTART_EN  = 2'd2,
    REG_RESTART_TIMEOUT  = 2'd3
  } lrs_reg_t;

  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // Configuration reset values
  localparam logic [31:0] RETRY_INTERVAL_RST  = 32'd10000;
  localparam logic [7:0]  MAX_ATTEMPTS_RST    = 8'd10;
  localparam logic        AUTO_RESTART_RST    = 1'b0;
  localparam logic [31:0] RESTART_TIMEOUT_RST = 32'd300000;

  // Stream widths (byte padded)
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 16;

  // Result bit positions in out_tdata
  localparam int unsigned OB_UP      = 0;
  localparam int unsigned OB_DOWN    = 1;
  localparam int unsigned OB_RETRY   = 2;
  localparam int unsigned OB_RESTART = 3;
  localparam int unsigned OB_USED_LO = 4;
  localparam int unsigned OB_USED_HI = 11;

  typedef struct packed {
    logic [31:0] retry_interval_ms;
    logic [7:0]  max_attempts;
    logic        auto_restart_enable;
    logic [31:0] restart_timeout_ms;
  } lrs_cfg_t;

  typedef struct packed {
    logic        link_up;
    logic [31:0] now_ms;
  } lrs_in_t;

  typedef struct packed {
    logic       up_event;
    logic       down_event;
    logic       retry_request;
    logic       restart_request;
    logic [7:0] attempts_used;
  } lrs_res_t;

endpackage

// ===== src/lrs_cfg.sv =====
// Configuration register file of the link reconnect supervisor.
module lrs_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [lrs_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [lrs_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  output lrs_pkg::lrs_cfg_t                 cfg
);

  lrs_pkg::lrs_cfg_t cfg_r;
  lrs_pkg::lrs_cfg_t cfg_nxt;

  // Decode write
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (lrs_pkg::lrs_reg_t'(cfg_addr))
        lrs_pkg::REG_RETRY_INTERVAL:  cfg_nxt.retry_interval_ms   = cfg_wdata[31:0];
        lrs_pkg::REG_MAX_ATTEMPTS:    cfg_nxt.max_attempts        = cfg_wdata[7:0];
        lrs_pkg::REG_AUTO_RESTART_EN: cfg_nxt.auto_restart_enable = cfg_wdata[0];
        lrs_pkg::REG_RESTART_TIMEOUT: cfg_nxt.restart_timeout_ms  = cfg_wdata[31:0];
        default:                      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.retry_interval_ms   <= lrs_pkg::RETRY_INTERVAL_RST;
      cfg_r.max_attempts        <= lrs_pkg::MAX_ATTEMPTS_RST;
      cfg_r.auto_restart_enable <= lrs_pkg::AUTO_RESTART_RST;
      cfg_r.restart_timeout_ms  <= lrs_pkg::RESTART_TIMEOUT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== src/lrs_core.sv =====
// Link supervisor state and per-beat event logic.
module lrs_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  lrs_pkg::lrs_cfg_t cfg,
  input  lrs_pkg::lrs_in_t  item,
  output lrs_pkg::lrs_res_t res
);

  logic        was_up_r,    was_up_nxt;
  logic [31:0] last_chk_r,  last_chk_nxt;
  logic [31:0] out_start_r, out_start_nxt;
  logic        out_act_r,   out_act_nxt;
  logic [7:0]  att_cnt_r,   att_cnt_nxt;

  logic [31:0] since_chk;
  logic [31:0] since_out;
  logic        drop;
  logic        due;
  logic        tmo_hit;

  assign since_chk = item.now_ms - last_chk_r;
  assign since_out = item.now_ms - out_start_r;
  assign drop      = !item.link_up && was_up_r;
  assign due       = since_chk >= cfg.retry_interval_ms;
  // On the drop beat the outage is zero long
  assign tmo_hit   = drop ? (cfg.restart_timeout_ms == 32'd0)
                          : (since_out >= cfg.restart_timeout_ms);

  // Next state and result
  always_comb begin
    was_up_nxt    = was_up_r;
    last_chk_nxt  = last_chk_r;
    out_start_nxt = out_start_r;
    out_act_nxt   = out_act_r;
    att_cnt_nxt   = att_cnt_r;
    res           = '0;

    if (item.link_up) begin
      if (!was_up_r) begin
        was_up_nxt    = 1'b1;
        att_cnt_nxt   = 8'd0;
        out_act_nxt   = 1'b0;
        out_start_nxt = 32'd0;
        res.up_event  = 1'b1;
      end
    end else begin
      if (drop) begin
        was_up_nxt     = 1'b0;
        out_start_nxt  = item.now_ms;
        out_act_nxt    = 1'b1;
        res.down_event = 1'b1;
      end
      if (due) begin
        last_chk_nxt = item.now_ms;
        if (att_cnt_r < cfg.max_attempts) begin
          att_cnt_nxt       = att_cnt_r + 8'd1;
          res.retry_request = 1'b1;
        end
      end
      res.restart_request = cfg.auto_restart_enable && out_act_nxt && tmo_hit;
    end

    res.attempts_used = att_cnt_nxt;

    // Restart returns all state to reset values
    if (res.restart_request) begin
      was_up_nxt    = 1'b0;
      last_chk_nxt  = 32'd0;
      out_start_nxt = 32'd0;
      out_act_nxt   = 1'b0;
      att_cnt_nxt   = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      was_up_r    <= 1'b0;
      last_chk_r  <= 32'd0;
      out_start_r <= 32'd0;
      out_act_r   <= 1'b0;
      att_cnt_r   <= 8'd0;
    end else if (step) begin
      was_up_r    <= was_up_nxt;
      last_chk_r  <= last_chk_nxt;
      out_start_r <= out_start_nxt;
      out_act_r   <= out_act_nxt;
      att_cnt_r   <= att_cnt_nxt;
    end
  end

endmodule

// ===== src/link_reconnect_supervisor.sv =====
// Top level of the link reconnect supervisor: input register, event logic, result register.
// Takes one link status sample per beat and returns one result beat for each, at a
// sustained rate of one beat per clock cycle while the output is not stalled. A sample
// is captured in the input register, evaluated against the supervisor state by a single
// stage of compare logic (which also updates the state), and the result is held in the
// output register. Backpressure on the output stalls the stage; the input register is
// refilled in the same cycle its sample moves on.
// Configuration writes take effect on the next cycle and should be made while idle.
module link_reconnect_supervisor (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input beat: tdata = {pad, now_ms[31:0], link_up} from the lowest bit up: link_up, now_ms
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [lrs_pkg::IN_DATA_W-1:0]     in_tdata,
  // Result beat: tdata from the lowest bit up: up_event, down_event, retry_request,
  // restart_request, attempts_used[7:0], zero pad
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [lrs_pkg::OUT_DATA_W-1:0]    out_tdata,
  // Configuration write port
  input  logic                              cfg_we,
  input  logic [lrs_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [lrs_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  lrs_pkg::lrs_cfg_t cfg;
  lrs_pkg::lrs_in_t  in_item_r;
  lrs_pkg::lrs_res_t res;
  lrs_pkg::lrs_res_t out_res_r;
  logic              in_v_r;
  logic              out_v_r;
  logic              adv;
  logic              step;

  assign adv       = !out_v_r || out_tready;
  assign step      = in_v_r && adv;
  assign in_tready = !in_v_r || adv;

  lrs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lrs_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .cfg   (cfg),
    .item  (in_item_r),
    .res   (res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_item_r.link_up <= in_tdata[0];
      in_item_r.now_ms  <= in_tdata[32:1];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {4'd0, out_res_r.attempts_used, out_res_r.restart_request,
                       out_res_r.retry_request, out_res_r.down_event, out_res_r.up_event};

endmodule

// ===== src/lrs_chk.sv =====
// Port-level checker for the link reconnect supervisor, bound to the top level.
module lrs_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [lrs_pkg::OUT_DATA_W-1:0] out_tdata
);

  // No result beat straight out of reset
  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // Link cannot both come up and drop in one beat
  a_one_edge: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[lrs_pkg::OB_UP] && out_tdata[lrs_pkg::OB_DOWN]))
    else $error("up and down event together");

  // Coming up clears the count and issues no retry or restart
  a_up_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[lrs_pkg::OB_UP] |->
      out_tdata[lrs_pkg::OB_USED_HI:lrs_pkg::OB_USED_LO] == 8'd0 &&
      !out_tdata[lrs_pkg::OB_RETRY] && !out_tdata[lrs_pkg::OB_RESTART])
    else $error("up event with retry, restart or attempts");

  // Nothing upstream waits while the output is free
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

endmodule

bind link_reconnect_supervisor lrs_chk u_lrs_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== sim/tb_link_reconnect_supervisor.sv =====
// Self-checking testbench for the link reconnect supervisor: stream stimulus, event prediction, checks.

// Tracks supervisor state, predicts the event flags of each sample and checks result beats.
class link_event_board;
  lrs_pkg::lrs_cfg_t cfg;
  logic              was_up;
  logic [31:0]       last_check;
  logic [31:0]       outage_start;
  logic              outage_active;
  logic [7:0]        attempts;
  lrs_pkg::lrs_res_t expected_events[$];
  int unsigned       mismatches;
  int unsigned       beats_seen;

  function void clear_state();
    was_up        = 1'b0;
    last_check    = '0;
    outage_start  = '0;
    outage_active = 1'b0;
    attempts      = '0;
  endfunction

  function void power_on();
    cfg.retry_interval_ms   = lrs_pkg::RETRY_INTERVAL_RST;
    cfg.max_attempts        = lrs_pkg::MAX_ATTEMPTS_RST;
    cfg.auto_restart_enable = lrs_pkg::AUTO_RESTART_RST;
    cfg.restart_timeout_ms  = lrs_pkg::RESTART_TIMEOUT_RST;
    clear_state();
    expected_events.delete();
  endfunction

  function int pending();
    return expected_events.size();
  endfunction

  task report_mismatch(string what);
    $display("MISMATCH at result beat %0d: %s", beats_seen, what);
    mismatches++;
  endtask

  // One accepted sample: update state and queue the events it must produce
  function void note_sample(logic up, logic [31:0] now);
    lrs_pkg::lrs_res_t ev;
    logic [31:0]       since_check;
    logic [31:0]       outage_len;
    ev = '0;
    if (up) begin
      if (!was_up) begin
        was_up        = 1'b1;
        attempts      = '0;
        outage_active = 1'b0;
        outage_start  = '0;
        ev.up_event   = 1'b1;
      end
    end else begin
      if (was_up) begin
        was_up        = 1'b0;
        outage_start  = now;
        outage_active = 1'b1;
        ev.down_event = 1'b1;
      end
      since_check = now - last_check;
      if (since_check >= cfg.retry_interval_ms) begin
        last_check = now;
        if (attempts < cfg.max_attempts) begin
          attempts         = attempts + 8'd1;
          ev.retry_request = 1'b1;
        end
      end
      outage_len = now - outage_start;
      if (cfg.auto_restart_enable && outage_active && outage_len >= cfg.restart_timeout_ms)
        ev.restart_request = 1'b1;
    end
    ev.attempts_used = attempts;
    // restart reports the count first, then drops back to reset state
    if (ev.restart_request) clear_state();
    expected_events.push_back(ev);
  endfunction

  // Compare a result beat against the oldest expectation, field by field
  task check_events(logic [lrs_pkg::OUT_DATA_W-1:0] beat);
    lrs_pkg::lrs_res_t want;
    logic [7:0]        used;
    beats_seen++;
    if (expected_events.size() == 0) begin
      report_mismatch("result beat with nothing expected");
      return;
    end
    want = expected_events.pop_front();
    used = beat[lrs_pkg::OB_USED_HI:lrs_pkg::OB_USED_LO];
    if (beat[lrs_pkg::OB_UP] !== want.up_event)
      report_mismatch($sformatf("up_event %b, want %b", beat[lrs_pkg::OB_UP], want.up_event));
    if (beat[lrs_pkg::OB_DOWN] !== want.down_event)
      report_mismatch($sformatf("down_event %b, want %b",
                                beat[lrs_pkg::OB_DOWN], want.down_event));
    if (beat[lrs_pkg::OB_RETRY] !== want.retry_request)
      report_mismatch($sformatf("retry_request %b, want %b",
                                beat[lrs_pkg::OB_RETRY], want.retry_request));
    if (beat[lrs_pkg::OB_RESTART] !== want.restart_request)
      report_mismatch($sformatf("restart_request %b, want %b",
                                beat[lrs_pkg::OB_RESTART], want.restart_request));
    if (used !== want.attempts_used)
      report_mismatch($sformatf("attempts_used %0d, want %0d", used, want.attempts_used));
  endtask
endclass

module tb_link_reconnect_supervisor;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 3000;

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  // from bit 0 up: link_up, now_ms[31:0], zero pad
  logic [lrs_pkg::IN_DATA_W-1:0]  in_tdata  = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  // from bit 0 up: up_event, down_event, retry_request, restart_request, attempts_used, pad
  logic [lrs_pkg::OUT_DATA_W-1:0] out_tdata;
  logic                           cfg_we    = 1'b0;
  logic [lrs_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [lrs_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  link_event_board board = new();

  // sample generator state
  logic        link_now   = 1'b0;
  int          run_left   = 0;
  logic [31:0] now_q      = '0;
  int unsigned step_max   = 100;
  int          burst_left = 0;

  always #5 clk = ~clk;

  link_reconnect_supervisor i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // Offer one sample beat, wait for acceptance, then idle per the burst pattern
  task automatic send_sample(logic up, logic [31:0] now);
    logic [lrs_pkg::IN_DATA_W-1:0] word;
    int                            gap;
    word      = '0;
    word[0]   = up;
    word[32:1] = now;
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    board.note_sample(up, now);
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    gap        = $urandom_range(0, 6);
    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every expected result beat has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  // Write all four registers while idle; junk in unused upper bits must be ignored
  task automatic reconfigure(lrs_pkg::lrs_cfg_t c);
    logic [31:0] junk;
    drain();
    repeat (3) @(posedge clk);
    junk      = $urandom;
    cfg_we    <= 1'b1;
    cfg_addr  <= lrs_pkg::REG_RETRY_INTERVAL;
    cfg_wdata <= c.retry_interval_ms;
    @(posedge clk);
    cfg_addr  <= lrs_pkg::REG_MAX_ATTEMPTS;
    cfg_wdata <= {junk[31:8], c.max_attempts};
    @(posedge clk);
    cfg_addr  <= lrs_pkg::REG_AUTO_RESTART_EN;
    cfg_wdata <= {junk[31:1], c.auto_restart_enable};
    @(posedge clk);
    cfg_addr  <= lrs_pkg::REG_RESTART_TIMEOUT;
    cfg_wdata <= c.restart_timeout_ms;
    @(posedge clk);
    cfg_we    <= 1'b0;
    board.cfg = c;
  endtask

  function automatic lrs_pkg::lrs_cfg_t pick_config();
    lrs_pkg::lrs_cfg_t c;
    case ($urandom_range(0, 4))
      0:       c.retry_interval_ms = 32'd0;
      1:       c.retry_interval_ms = $urandom_range(1, 20);
      2:       c.retry_interval_ms = $urandom_range(50, 2000);
      3:       c.retry_interval_ms = $urandom;
      default: c.retry_interval_ms = 32'd10000;
    endcase
    case ($urandom_range(0, 3))
      0:       c.max_attempts = 8'd0;
      1:       c.max_attempts = 8'($urandom_range(1, 4));
      2:       c.max_attempts = 8'($urandom_range(5, 20));
      default: c.max_attempts = 8'd255;
    endcase
    c.auto_restart_enable = ($urandom_range(0, 3) != 0);
    case ($urandom_range(0, 3))
      0:       c.restart_timeout_ms = 32'd0;
      1:       c.restart_timeout_ms = $urandom_range(1, 3000);
      2:       c.restart_timeout_ms = $urandom;
      default: c.restart_timeout_ms = 32'hFFFF_FFFF;
    endcase
    return c;
  endfunction

  // Link runs up and down with a moving clock; many times land on the retry and restart edges
  task automatic run_samples(int n);
    logic up;
    int   k;
    repeat (n) begin
      if (run_left == 0) begin
        link_now = ~link_now;
        run_left = $urandom_range(1, 10);
      end
      run_left--;
      up = link_now;
      if ($urandom_range(0, 99) < 8) up = ~link_now;
      k = $urandom_range(0, 99);
      if (k < 45)
        now_q = now_q + 32'($urandom_range(0, step_max));
      else if (k < 65)
        now_q = board.last_check + board.cfg.retry_interval_ms - 32'd1
                + 32'($urandom_range(0, 2));
      else if (k < 80)
        now_q = board.outage_start + board.cfg.restart_timeout_ms - 32'd1
                + 32'($urandom_range(0, 2));
      else if (k < 90)
        now_q = $urandom;
      else
        now_q = now_q - 32'($urandom_range(1, 50));
      send_sample(up, now_q);
    end
  endtask

  // Main sequence
  initial begin
    lrs_pkg::lrs_cfg_t c;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    board.power_on();
    @(posedge clk);

    // reset settings: down before any up, retries, wrap of the ms clock
    send_sample(1'b0, 32'd0);
    send_sample(1'b0, 32'd10000);
    send_sample(1'b1, 32'd10001);
    send_sample(1'b1, 32'd10002);
    send_sample(1'b0, 32'd20000);
    send_sample(1'b0, 32'd25000);
    send_sample(1'b0, 32'hFFFF_FFFF);
    send_sample(1'b0, 32'd9998);
    send_sample(1'b0, 32'd9999);
    send_sample(1'b1, 32'hFFFF_FFFF);

    // check every tick, two attempts, short timeout: exhaustion then restart
    c = '{retry_interval_ms: 32'd0, max_attempts: 8'd2, auto_restart_enable: 1'b1,
          restart_timeout_ms: 32'd5};
    reconfigure(c);
    send_sample(1'b0, 32'd100);
    send_sample(1'b0, 32'd101);
    send_sample(1'b0, 32'd102);
    send_sample(1'b0, 32'd105);
    send_sample(1'b0, 32'd106);
    send_sample(1'b1, 32'd107);

    // zero timeout restarts on the drop itself; widest interval
    c = '{retry_interval_ms: 32'hFFFF_FFFF, max_attempts: 8'd255, auto_restart_enable: 1'b1,
          restart_timeout_ms: 32'd0};
    reconfigure(c);
    send_sample(1'b0, 32'd200);
    send_sample(1'b1, 32'd0);
    send_sample(1'b0, 32'hFFFF_FFFF);

    // random phases, each under its own settings
    for (int p = 0; p < 10; p++) begin
      if (p == 0)
        c = '{retry_interval_ms: 32'd0, max_attempts: 8'd0, auto_restart_enable: 1'b0,
              restart_timeout_ms: 32'd0};
      else if (p == 1)
        c = '{retry_interval_ms: 32'hFFFF_FFFF, max_attempts: 8'd255,
              auto_restart_enable: 1'b1, restart_timeout_ms: 32'hFFFF_FFFF};
      else
        c = pick_config();
      reconfigure(c);
      step_max = $urandom_range(1, 3000);
      if (p == 3) begin
        run_samples(45);
        drain();
        run_samples(48);
      end else begin
        run_samples(93);
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (board.pending() != 0) board.report_mismatch("expected results left over");
    if (board.mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // Result side: check each beat, stall on a changing pattern, one long hold-off
  initial begin
    int   mode;
    int   mode_left;
    int   hold_left;
    int   taken;
    bit   held;
    logic rdy;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    taken     = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        board.check_events(out_tdata);
        taken++;
      end
      if (taken >= 300 && !held) begin
        held      = 1'b1;
        hold_left = 300;
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 80);
      end
      mode_left--;
      case (mode)
        0:       rdy = 1'b1;
        1:       rdy = 1'($urandom_range(0, 1));
        2:       rdy = ($urandom_range(0, 3) == 0);
        default: rdy = ($urandom_range(0, 4) != 0);
      endcase
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end
      out_tready <= rdy;
    end
  end

  // Watchdog: too many cycles without any beat on either side ends the run
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
